[hdl/hre_pkg.sv]
// ----------------------------------------------------------------------------
// hre_pkg: shared constants and helpers for the reprojection error block
// Widths of the point, matrix and accumulator formats, register indexes and
// the matrix entry extraction used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hre_pkg;

  // field and datapath widths
  localparam int unsigned CoordW  = 20;
  localparam int unsigned EntW    = 21;
  localparam int unsigned RowW    = 63;
  localparam int unsigned MeanW   = 48;
  localparam int unsigned SumW    = 64;
  localparam int unsigned WW      = 44;
  localparam int unsigned DivW    = 64;
  localparam int unsigned MulW    = 32;
  localparam int unsigned DiffW   = 31;
  localparam int unsigned CntW    = 17;
  localparam int unsigned CfgIdxW = 2;

  // largest set size that is still summed
  localparam logic [CntW-1:0] MaxPoints = 17'd65536;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgRow0 = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRow1 = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRow2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMode = 2'd3;

  // identity matrix at reset, squared distance mode
  localparam logic [RowW-1:0] Row0Rst = 63'd4096;
  localparam logic [RowW-1:0] Row1Rst = 63'd8589934592;
  localparam logic [RowW-1:0] Row2Rst = 63'd18014398509481984;
  localparam logic            ModeRst = 1'b1;

  // saturation limits
  localparam logic [SumW-1:0]  DiffClamp = 64'h0000_0000_7FFF_FFFF;
  localparam logic [MeanW-1:0] MeanMax   = {MeanW{1'b1}};

  // signed Q8.12 entry of one matrix row, column 0 in the low bits
  function automatic logic signed [EntW-1:0] mat_entry(input logic [RowW-1:0] row,
                                                       input logic [1:0] col);
    logic signed [EntW-1:0] e;
    case (col)
      2'd0:    e = $signed(row[20:0]);
      2'd1:    e = $signed(row[41:21]);
      2'd2:    e = $signed(row[62:42]);
      default: e = $signed(row[20:0]);
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

[hdl/hre_if.sv]
// ----------------------------------------------------------------------------
// hre_if: point pair and result channels
// Valid/ready channels carrying one correspondence in and one set result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hre_in_if
  import hre_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] src_x;
  logic [CoordW-1:0] src_y;
  logic [CoordW-1:0] tgt_x;
  logic [CoordW-1:0] tgt_y;
  logic              last;

  modport source (output valid, src_x, src_y, tgt_x, tgt_y, last, input ready);
  modport sink   (input valid, src_x, src_y, tgt_x, tgt_y, last, output ready);
  modport monitor (input valid, ready, src_x, src_y, tgt_x, tgt_y, last);
endinterface

interface hre_out_if
  import hre_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [MeanW-1:0] mean_error;
  logic [CntW-1:0]  point_count;
  logic             degenerate;

  modport source (output valid, mean_error, point_count, degenerate, input ready);
  modport sink   (input valid, mean_error, point_count, degenerate, output ready);
  modport monitor (input valid, ready, mean_error, point_count, degenerate);
endinterface

`default_nettype wire

[hdl/hre_div.sv]
// ----------------------------------------------------------------------------
// hre_div: radix-2 restoring unsigned divider
// 64-bit dividend and divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hre_div
  import hre_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DivW-1:0] dividend_i,
  input  wire logic [DivW-1:0] divisor_i,
  output logic                 done_o,
  output logic [DivW-1:0]      quot_o
);

  localparam int unsigned StepW = $clog2(DivW + 1);

  logic [DivW:0]    rem_q, rem_d;
  logic [DivW-1:0]  quo_q, quo_d;
  logic [DivW-1:0]  dvs_q, dvs_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DivW:0]    rem_sh;
  logic             ge;

  // one shift, compare and subtract step
  always_comb begin
    rem_sh = {rem_q[DivW-1:0], quo_q[DivW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = StepW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

[hdl/homography_reprojection_error_top.sv]
// ----------------------------------------------------------------------------
// homography_reprojection_error_top: mean reprojection error of a point set
// Projects each source point by a 3x3 homography, compares with the target
// and accumulates the Euclidean or squared distance; emits the mean per set.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_i      in   valid/ready   src_x, src_y, tgt_x, tgt_y, last
//  out_o     out  valid/ready   mean_error, point_count, degenerate
//  cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i (write only)
//
//  one pair at a time: each pair runs the multiplier steps and two passes of
//  the shared divider, and in Euclidean mode the 32-step square root; a last
//  item adds a pass of the shared divider for the mean division.
//  a degenerate pair skips the divisions and the distance; one past the point limit is not summed.
//  reset clears accumulators and loads the identity matrix; no clearing pass.
//  a waiting result stalls only the next last item, not the pairs before it.
// ----------------------------------------------------------------------------
`default_nettype none

module homography_reprojection_error_top
  import hre_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  hre_in_if.sink                  in_i,
  hre_out_if.source               out_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [RowW-1:0]    cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_DIVX = 4'd3;
  localparam logic [3:0] S_DIVY = 4'd4;
  localparam logic [3:0] S_DIFF = 4'd5;
  localparam logic [3:0] S_SQ   = 4'd6;
  localparam logic [3:0] S_ROOT = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_MEAN = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]            state_q, state_d;
  logic [RowW-1:0]       row0_q, row1_q, row2_q;
  logic                  mode_q;
  logic [SumW-1:0]       sum_q, sum_d;
  logic [CntW-1:0]       pts_q, pts_d;
  logic                  deg_q, deg_d;
  logic [4:0]            k_q, k_d;

  logic signed [CoordW-1:0] sx_q, sy_q, tx_q, ty_q;
  logic                     last_q;
  logic signed [WW-1:0]     w0_q, w1_q, w2_q, w0_d, w1_d, w2_d;
  logic signed [2*MulW-1:0] prod_q;
  logic signed [SumW-1:0]   px_q, px_d, py_q, py_d;
  logic [DiffW-1:0]         dx_q, dy_q, dx_d, dy_d;
  logic [SumW-1:0]          sq_q, sq_d, res_q, res_d, bit_q, bit_d, err_q, err_d;
  logic [MeanW-1:0]         mean_q, mean_d;

  logic                  ov_q, ov_d;
  logic [MeanW-1:0]      omean_q, omean_d;
  logic [CntW-1:0]       ocnt_q, ocnt_d;
  logic                  odeg_q, odeg_d;

  logic                     div_start, div_done;
  logic [DivW-1:0]          div_dividend, div_divisor, div_quot;
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [2*MulW-1:0] mul_prod;
  logic [RowW-1:0]          mrow;
  logic [WW-1:0]            abs_w0, abs_w1, abs_w2;
  logic                     neg_x, neg_y;
  logic signed [SumW-1:0]   qs, ddx, ddy;
  logic [SumW-1:0]          adx, ady, sq_sum, root_t;
  logic [SumW:0]            acc_sum;
  logic                     out_free;
  logic [1:0]               widx;

  // shared divider
  hre_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // magnitudes of the homogeneous products
  assign abs_w0 = w0_q[WW-1] ? WW'(-w0_q) : WW'(w0_q);
  assign abs_w1 = w1_q[WW-1] ? WW'(-w1_q) : WW'(w1_q);
  assign abs_w2 = w2_q[WW-1] ? WW'(-w2_q) : WW'(w2_q);
  assign neg_x  = w0_q[WW-1] ^ w2_q[WW-1];
  assign neg_y  = w1_q[WW-1] ^ w2_q[WW-1];
  assign qs     = $signed(div_quot);

  // shared multiplier operands
  always_comb begin
    case (k_q[2:1])
      2'd0:    mrow = row0_q;
      2'd1:    mrow = row1_q;
      default: mrow = row2_q;
    endcase
    if (state_q == S_SQ) begin
      mul_a = $signed({1'b0, (k_q[0] ? dy_q : dx_q)});
      mul_b = mul_a;
    end else begin
      mul_a = MulW'(mat_entry(mrow, {1'b0, k_q[0]}));
      mul_b = MulW'(k_q[0] ? sy_q : sx_q);
    end
  end
  assign mul_prod = mul_a * mul_b;

  // differences to the target, clamped magnitudes
  assign ddx = ($signed(SumW'(tx_q)) <<< 4) - px_q;
  assign ddy = ($signed(SumW'(ty_q)) <<< 4) - py_q;
  assign adx = ddx[SumW-1] ? SumW'(-ddx) : SumW'(ddx);
  assign ady = ddy[SumW-1] ? SumW'(-ddy) : SumW'(ddy);

  assign sq_sum  = sq_q + SumW'(prod_q);
  assign root_t  = res_q + bit_q;
  assign acc_sum = {1'b0, sum_q} + {1'b0, err_q};
  assign out_free = !ov_q || out_o.ready;
  assign widx     = 2'((k_q - 5'd1) >> 1);

  // divider operand selection
  always_comb begin
    div_start    = 1'b0;
    div_dividend = SumW'(abs_w0) << 8;
    div_divisor  = SumW'(abs_w2);
    case (state_q)
      S_CHK:  div_start = (w2_q != '0);
      S_DIVX: begin
        div_start    = div_done;
        div_dividend = SumW'(abs_w1) << 8;
      end
      S_FIN:  begin
        div_start    = last_q;
        div_dividend = sum_q;
        div_divisor  = SumW'(pts_q);
      end
      default: div_start = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    pts_d   = pts_q;
    deg_d   = deg_q;
    k_d     = k_q;
    w0_d    = w0_q;
    w1_d    = w1_q;
    w2_d    = w2_q;
    px_d    = px_q;
    py_d    = py_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    sq_d    = sq_q;
    res_d   = res_q;
    bit_d   = bit_q;
    err_d   = err_q;
    mean_d  = mean_q;
    ov_d    = ov_q && !out_o.ready;
    omean_d = omean_q;
    ocnt_d  = ocnt_q;
    odeg_d  = odeg_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          k_d  = '0;
          w0_d = $signed({{(WW-EntW-4){row0_q[RowW-1]}},
                          row0_q[RowW-1:2*EntW], 4'b0});
          w1_d = $signed({{(WW-EntW-4){row1_q[RowW-1]}},
                          row1_q[RowW-1:2*EntW], 4'b0});
          w2_d = $signed({{(WW-EntW-4){row2_q[RowW-1]}},
                          row2_q[RowW-1:2*EntW], 4'b0});
          state_d = (pts_q < MaxPoints) ? S_MUL : S_FIN;
        end
      end
      S_MUL: begin
        if (k_q != '0) begin
          case (widx)
            2'd0:    w0_d = w0_q + $signed(prod_q[WW-1:0]);
            2'd1:    w1_d = w1_q + $signed(prod_q[WW-1:0]);
            default: w2_d = w2_q + $signed(prod_q[WW-1:0]);
          endcase
        end
        k_d = k_q + 5'd1;
        if (k_q == 5'd6) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (w2_q == '0) begin
          deg_d   = 1'b1;
          sum_d   = '1;
          pts_d   = pts_q + CntW'(1);
          state_d = S_FIN;
        end else begin
          state_d = S_DIVX;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          px_d    = neg_x ? -qs : qs;
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          py_d    = neg_y ? -qs : qs;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        dx_d    = DiffW'((adx > DiffClamp) ? DiffClamp : adx);
        dy_d    = DiffW'((ady > DiffClamp) ? DiffClamp : ady);
        sq_d    = '0;
        k_d     = '0;
        state_d = S_SQ;
      end
      S_SQ: begin
        k_d = k_q + 5'd1;
        if (k_q != '0) begin
          sq_d = sq_sum;
        end
        if (k_q == 5'd2) begin
          k_d   = '0;
          res_d = '0;
          bit_d = SumW'(1) << 62;
          if (mode_q) begin
            err_d   = sq_sum >> 8;
            state_d = S_ACC;
          end else begin
            state_d = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        if (sq_q >= root_t) begin
          sq_d  = sq_q - root_t;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        k_d   = k_q + 5'd1;
        if (k_q == 5'd31) begin
          err_d   = res_d;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        sum_d   = acc_sum[SumW] ? '1 : acc_sum[SumW-1:0];
        pts_d   = pts_q + CntW'(1);
        state_d = S_FIN;
      end
      S_FIN: begin
        state_d = last_q ? S_MEAN : S_IDLE;
      end
      S_MEAN: begin
        if (div_done) begin
          mean_d  = (div_quot > SumW'(MeanMax)) ? MeanMax : div_quot[MeanW-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          omean_d = mean_q;
          ocnt_d  = pts_q;
          odeg_d  = deg_q;
          sum_d   = '0;
          pts_d   = '0;
          deg_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state, configuration and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row0_q  <= Row0Rst;
      row1_q  <= Row1Rst;
      row2_q  <= Row2Rst;
      mode_q  <= ModeRst;
      sum_q   <= '0;
      pts_q   <= '0;
      deg_q   <= 1'b0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      pts_q   <= pts_d;
      deg_q   <= deg_d;
      k_q     <= k_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRow0: row0_q <= cfg_data_i;
          CfgRow1: row1_q <= cfg_data_i;
          CfgRow2: row2_q <= cfg_data_i;
          CfgMode: mode_q <= cfg_data_i[0];
          default: mode_q <= mode_q;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      sx_q   <= $signed(in_i.src_x);
      sy_q   <= $signed(in_i.src_y);
      tx_q   <= $signed(in_i.tgt_x);
      ty_q   <= $signed(in_i.tgt_y);
      last_q <= in_i.last;
    end
    prod_q  <= mul_prod;
    w0_q    <= w0_d;
    w1_q    <= w1_d;
    w2_q    <= w2_d;
    px_q    <= px_d;
    py_q    <= py_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    sq_q    <= sq_d;
    res_q   <= res_d;
    bit_q   <= bit_d;
    err_q   <= err_d;
    mean_q  <= mean_d;
    omean_q <= omean_d;
    ocnt_q  <= ocnt_d;
    odeg_q  <= odeg_d;
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = ov_q;
  assign out_o.mean_error  = omean_q;
  assign out_o.point_count = ocnt_q;
  assign out_o.degenerate  = odeg_q;

endmodule

`default_nettype wire

[hdl/hre_checker.sv]
// ----------------------------------------------------------------------------
// hre_checker: port-level checks for the reprojection error block
// Watches the channels of the top level; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module hre_checker
  import hre_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [MeanW-1:0] out_mean_error_i,
  input wire logic [CntW-1:0]  out_point_count_i,
  input wire logic             out_degenerate_i
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its mean
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_mean_error_i))
    else $error("mean changed while stalled");

  // one pair at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("pair taken while busy");

  // a finished set holds at least one pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_point_count_i != '0)
    else $error("empty set reported");

  // a degenerate set reports a saturated mean
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_degenerate_i |-> out_mean_error_i == MeanMax)
    else $error("degenerate set without saturated mean");

endmodule

bind homography_reprojection_error_top hre_checker u_hre_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_mean_error_i  (out_o.mean_error),
  .out_point_count_i (out_o.point_count),
  .out_degenerate_i  (out_o.degenerate)
);

`default_nettype wire
